### design/sqw_pkg.sv
// Shared types and constants for the square-wave note sequencer.
package sqw_pkg;

    localparam int MAX_NOTES_DEF = 128;
    localparam int HALF_W        = 24;
    localparam int DUR_W         = 32;
    localparam int IDX_OUT_W     = 7;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [HALF_W-1:0] half_period;
        logic [DUR_W-1:0]  duration_ticks;
        logic              last_note;
    } in_item_t;

    typedef struct packed {
        logic                 pin_level;
        logic                 playing;
        logic                 note_started;
        logic [IDX_OUT_W-1:0] note_index;
        logic                 finished;
    } out_item_t;

endpackage

### design/square_wave_note_sequencer_core.sv
// Square-wave note sequencer: note stores in RAM, tick-driven playback control.
// Load passes dispatch (then start read and start load when it starts playback);
// a tick passes dispatch and tick evaluate (dispatch only when idle, plus next load
// when playback moves to the next note). The result strobe comes in the cycle
// after the last working cycle; busy drops in that same cycle. One transaction at a time.
// Note reads share the single RAM read port. Reset clears all control state; note stores are undefined until loaded.
module square_wave_note_sequencer_core
    import sqw_pkg::*;
#(
    parameter int MAX_NOTES = MAX_NOTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      result_valid,
    output out_item_t result
);

    localparam int IDX_W = $clog2(MAX_NOTES);
    localparam int CNT_W = $clog2(MAX_NOTES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_START_RD,
        ST_START_LD,
        ST_TICK_EVAL,
        ST_NEXT_LD
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic              active_reg, active_next;
    logic              pin_reg, pin_next;
    logic [HALF_W-1:0] counter_reg, counter_next;
    logic [DUR_W-1:0]  elapsed_reg, elapsed_next;
    logic              valid_reg, valid_next;
    out_item_t         result_reg, result_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [HALF_W-1:0] period_rdata;
    logic [DUR_W-1:0]  length_rdata;

    sqw_ram #(
        .WIDTH(HALF_W),
        .DEPTH(MAX_NOTES)
    ) u_period_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(total_reg[IDX_W-1:0]),
        .wdata(item_reg.half_period),
        .raddr(ram_raddr),
        .rdata(period_rdata)
    );

    sqw_ram #(
        .WIDTH(DUR_W),
        .DEPTH(MAX_NOTES)
    ) u_length_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(total_reg[IDX_W-1:0]),
        .wdata(item_reg.duration_ticks),
        .raddr(ram_raddr),
        .rdata(length_rdata)
    );

    always_comb
    begin
        logic             emit;
        logic             started;
        logic             fin;
        logic [IDX_W-1:0] cur_inc;
        emit         = 1'b0;
        started      = 1'b0;
        fin          = 1'b0;
        cur_inc      = cur_reg + IDX_W'(1);
        state_next   = state_reg;
        item_next    = item_reg;
        total_next   = total_reg;
        cur_next     = cur_reg;
        active_next  = active_reg;
        pin_next     = pin_reg;
        counter_next = counter_reg;
        elapsed_next = elapsed_reg;
        ram_we       = 1'b0;
        ram_raddr    = cur_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (item_reg.req_type == REQ_LOAD)
                begin
                    emit = 1'b1;
                    if (!active_reg)
                    begin
                        if (total_reg < CNT_W'(MAX_NOTES))
                        begin
                            ram_we     = 1'b1;
                            total_next = total_reg + CNT_W'(1);
                        end
                        if (item_reg.last_note && (total_next != '0))
                        begin
                            emit       = 1'b0;
                            state_next = ST_START_RD;
                        end
                    end
                end
                else if (active_reg)
                begin
                    if (elapsed_reg != '1)
                    begin
                        elapsed_next = elapsed_reg + DUR_W'(1);
                    end
                    state_next = ST_TICK_EVAL;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            ST_START_RD:
            begin
                ram_raddr  = '0;
                state_next = ST_START_LD;
            end
            ST_START_LD:
            begin
                cur_next     = '0;
                elapsed_next = '0;
                counter_next = period_rdata;
                active_next  = 1'b1;
                pin_next     = ~pin_reg;
                started      = 1'b1;
                emit         = 1'b1;
            end
            ST_TICK_EVAL:
            begin
                emit = 1'b1;
                if (counter_reg <= HALF_W'(1))
                begin
                    pin_next = ~pin_reg;
                    if (elapsed_reg > length_rdata)
                    begin
                        if (CNT_W'(cur_reg) + CNT_W'(1) >= total_reg)
                        begin
                            active_next  = 1'b0;
                            total_next   = '0;
                            counter_next = '0;
                            fin          = 1'b1;
                        end
                        else
                        begin
                            ram_raddr  = cur_inc;
                            emit       = 1'b0;
                            state_next = ST_NEXT_LD;
                        end
                    end
                    else
                    begin
                        counter_next = period_rdata;
                    end
                end
                else
                begin
                    counter_next = counter_reg - HALF_W'(1);
                end
            end
            ST_NEXT_LD:
            begin
                cur_next     = cur_inc;
                elapsed_next = '0;
                counter_next = period_rdata;
                started      = 1'b1;
                emit         = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        valid_next  = emit;
        result_next = result_reg;
        if (emit)
        begin
            state_next               = ST_IDLE;
            result_next.pin_level    = pin_next;
            result_next.playing      = active_next;
            result_next.note_started = started;
            result_next.note_index   = IDX_OUT_W'(cur_next);
            result_next.finished     = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            item_reg    <= '0;
            total_reg   <= '0;
            cur_reg     <= '0;
            active_reg  <= 1'b0;
            pin_reg     <= 1'b0;
            counter_reg <= '0;
            elapsed_reg <= '0;
            valid_reg   <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            item_reg    <= item_next;
            total_reg   <= total_next;
            cur_reg     <= cur_next;
            active_reg  <= active_next;
            pin_reg     <= pin_next;
            counter_reg <= counter_next;
            elapsed_reg <= elapsed_next;
            valid_reg   <= valid_next;
            result_reg  <= result_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !result_valid)
        else $error("accepted transaction did not make the block busy");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while still busy");

    a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.finished |-> !result.playing && !result.note_started)
        else $error("finished melody still reported as playing");

    a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.note_started |-> result.playing)
        else $error("note started while not playing");

endmodule

### design/sqw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sqw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/sv/tb_square_wave_note_sequencer_core.sv
// Self-checking testbench: note loads and timer ticks checked against a tick-level predictor.
`timescale 1ns / 1ps

module tb_square_wave_note_sequencer_core;
    import sqw_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  req_item;
    logic      result_valid;
    out_item_t status;

    square_wave_note_sequencer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (req_item),
        .result_valid (result_valid),
        .result       (status)
    );

    // Predictor state
    logic [HALF_W-1:0] tone_period [MAX_NOTES_DEF];
    logic [DUR_W-1:0]  tone_length [MAX_NOTES_DEF];
    int                notes_held;
    int                note_at;
    logic              playing_now;
    logic              pin_now;
    logic [HALF_W-1:0] half_left;
    logic [DUR_W-1:0]  ticks_in_note;

    out_item_t status_queue[$];
    out_item_t want;
    int        errors;
    int        items_sent;
    int        melodies;
    int        notes_begun;
    int        melodies_done;
    int        burst_left;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void enter_note(int idx);
        note_at       = idx;
        ticks_in_note = '0;
        half_left     = tone_period[idx];
    endfunction

    function automatic out_item_t play_step(in_item_t it);
        out_item_t o;
        logic      started;
        logic      done;
        started = 1'b0;
        done    = 1'b0;
        if (it.req_type == REQ_LOAD)
        begin
            if (!playing_now)
            begin
                if (notes_held < MAX_NOTES_DEF)
                begin
                    tone_period[notes_held] = it.half_period;
                    tone_length[notes_held] = it.duration_ticks;
                    notes_held++;
                end
                if (it.last_note && notes_held > 0)
                begin
                    playing_now = 1'b1;
                    enter_note(0);
                    pin_now = ~pin_now;
                    started = 1'b1;
                end
            end
        end
        else if (playing_now)
        begin
            if (ticks_in_note != '1)
                ticks_in_note++;
            if (half_left <= 1)
            begin
                pin_now = ~pin_now;
                if (ticks_in_note > tone_length[note_at])
                begin
                    if (note_at + 1 >= notes_held)
                    begin
                        playing_now = 1'b0;
                        notes_held  = 0;
                        half_left   = '0;
                        done        = 1'b1;
                    end
                    else
                    begin
                        enter_note(note_at + 1);
                        started = 1'b1;
                    end
                end
                else
                begin
                    half_left = tone_period[note_at];
                end
            end
            else
            begin
                half_left--;
            end
        end
        if (started)
            notes_begun++;
        if (done)
            melodies_done++;
        o.pin_level    = pin_now;
        o.playing      = playing_now;
        o.note_started = started;
        o.note_index   = note_at[IDX_OUT_W-1:0];
        o.finished     = done;
        return o;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (status_queue.size() == 0)
            begin
                $error("result strobe with no transaction pending");
                errors++;
            end
            else
            begin
                want = status_queue.pop_front();
                if (status.pin_level !== want.pin_level)
                begin
                    $error("pin_level: expected %0d, got %0d", want.pin_level, status.pin_level);
                    errors++;
                end
                if (status.playing !== want.playing)
                begin
                    $error("playing: expected %0d, got %0d", want.playing, status.playing);
                    errors++;
                end
                if (status.note_started !== want.note_started)
                begin
                    $error("note_started: expected %0d, got %0d",
                           want.note_started, status.note_started);
                    errors++;
                end
                if (status.note_index !== want.note_index)
                begin
                    $error("note_index: expected %0d, got %0d",
                           want.note_index, status.note_index);
                    errors++;
                end
                if (status.finished !== want.finished)
                begin
                    $error("finished: expected %0d, got %0d", want.finished, status.finished);
                    errors++;
                end
            end
        end
    end

    function automatic in_item_t load_item(logic [HALF_W-1:0] half, logic [DUR_W-1:0] dur,
                                           logic last);
        in_item_t it;
        it.req_type       = REQ_LOAD;
        it.half_period    = half;
        it.duration_ticks = dur;
        it.last_note      = last;
        return it;
    endfunction

    function automatic in_item_t tick_item();
        in_item_t it;
        logic [HALF_W-1:0] h;
        h = HALF_W'($urandom);
        it.req_type       = REQ_TICK;
        it.half_period    = h;
        it.duration_ticks = $urandom;
        it.last_note      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t noise_load();
        logic [HALF_W-1:0] h;
        h = HALF_W'($urandom);
        return load_item(h, $urandom, 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return HALF_W'($urandom_range(5, 30));
            default: return HALF_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] rand_dur();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(13, 50);
        return $urandom_range(0, 12);
    endfunction

    // Drive one transaction, wait for acceptance, then maybe open a gap
    task automatic send_item(in_item_t it);
        int gap;
        @(negedge clk);
        start    <= 1'b1;
        req_item <= it;
        do
            @(posedge clk);
        while (busy);
        status_queue.push_back(play_step(it));
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic play_out(bit with_noise);
        int guard;
        guard = 0;
        while (playing_now && guard < 3000)
        begin
            if (with_noise && $urandom_range(0, 7) == 0)
                send_item(noise_load());
            else
                send_item(tick_item());
            guard++;
        end
    endtask

    task automatic test_directed();
        send_item(tick_item());
        send_item(load_item(24'd1, 32'd0, 1'b0));
        send_item(load_item(24'd0, 32'd3, 1'b0));
        send_item(load_item(24'd2, 32'd1, 1'b1));
        send_item(load_item(24'hFFFFFF, 32'hFFFFFFFF, 1'b1));
        melodies++;
        play_out(1'b0);
        send_item(tick_item());
        wait_for_drain();
        send_item(load_item(24'd3, 32'd5, 1'b1));
        melodies++;
        play_out(1'b0);
    endtask

    task automatic test_random_melodies(int target);
        int goal;
        int n;
        goal = items_sent + target;
        while (items_sent < goal)
        begin
            repeat ($urandom_range(0, 2)) send_item(tick_item());
            // partial melody with stray ticks in between
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_item(load_item(rand_half(), rand_dur(), 1'b0));
                send_item(tick_item());
            end
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
                send_item(load_item(rand_half(), rand_dur(), k == n - 1));
            melodies++;
            play_out(1'b1);
            if ($urandom_range(0, 3) == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_store_full();
        for (int k = 0; k < MAX_NOTES_DEF; k++)
            send_item(load_item(HALF_W'($urandom_range(1, 2)), DUR_W'($urandom_range(0, 1)),
                                1'b0));
        send_item(load_item(24'hFFFFFF, 32'hFFFFFFFF, 1'b0));
        send_item(load_item(24'h000000, 32'h00000000, 1'b0));
        send_item(load_item(24'hFFFFFF, 32'hFFFFFFFF, 1'b1));
        melodies++;
        play_out(1'b1);
        send_item(tick_item());
    endtask

    // Runs last: a note of all-ones duration never ends
    task automatic test_endless_note();
        send_item(load_item(24'd1, 32'hFFFFFFFF, 1'b1));
        melodies++;
        repeat (30)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(noise_load());
            else
                send_item(tick_item());
        end
    endtask

    initial
    begin
        int guard;
        start         = 1'b0;
        req_item      = '0;
        rst_n         = 1'b0;
        errors        = 0;
        items_sent    = 0;
        melodies      = 0;
        notes_begun   = 0;
        melodies_done = 0;
        burst_left    = 4;
        notes_held    = 0;
        note_at       = 0;
        playing_now   = 1'b0;
        pin_now       = 1'b0;
        half_left     = '0;
        ticks_in_note = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_melodies(100);
        test_store_full();
        test_endless_note();

        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (status_queue.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (status_queue.size() != 0)
        begin
            $error("%0d transactions never produced a result", status_queue.size());
            errors++;
        end

        $display("Sent %0d transactions over %0d melodies, incl. a full store and an endless note.",
                 items_sent, melodies);
        $display("Saw %0d note starts and %0d melody ends; %0d mismatches.",
                 notes_begun, melodies_done, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
design/sqw_pkg.sv
design/sqw_ram.sv
design/square_wave_note_sequencer_core.sv
tb/sv/tb_square_wave_note_sequencer_core.sv
